[src/gcfam_pkg.sv]
// Shared types, constants and helpers for the command framer and acknowledge matcher.
package gcfam_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hB5;
    localparam logic [7:0] SYNC_SECOND  = 8'h62;
    localparam logic [7:0] ACK_CLASS    = 8'h05;
    localparam logic [7:0] BAD_RESPONSE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PAYLOAD = 2'd1,
        CMD_RECEIVE = 2'd2
    } t_command;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_PAYLOAD = 8'b0000_0010,
        PH_SCAN    = 8'b0000_0100,
        PH_CODE    = 8'b0000_1000,
        PH_LEN_LO  = 8'b0001_0000,
        PH_LEN_HI  = 8'b0010_0000,
        PH_CLASS   = 8'b0100_0000,
        PH_IDENT   = 8'b1000_0000
    } t_phase;

    // What kind of result run an accepted item causes
    typedef enum logic [2:0] {
        RUN_NONE     = 3'd0,
        RUN_HDR      = 3'd1,
        RUN_HDR_SUM  = 3'd2,
        RUN_BYTE     = 3'd3,
        RUN_BYTE_SUM = 3'd4,
        RUN_VERDICT  = 3'd5
    } t_run_mode;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  msg_class;
        logic [7:0]  msg_ident;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } t_cmd_item;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  tx_byte;
        logic        last_of_run;
        logic        response_matched;
        logic [7:0]  response_code;
    } t_result_item;

    typedef struct packed {
        t_run_mode  mode;
        logic [7:0] hdr_class;
        logic [7:0] hdr_ident;
        logic [7:0] len_lo;
        logic [7:0] len_hi;
        logic [7:0] data;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic       matched;
        logic [7:0] code;
    } t_run;

    function automatic logic [2:0] run_last(input t_run_mode mode);
        logic [2:0] last;
        case (mode)
            RUN_HDR:      last = 3'd5;
            RUN_HDR_SUM:  last = 3'd7;
            RUN_BYTE_SUM: last = 3'd2;
            default:      last = 3'd0;
        endcase
        return last;
    endfunction

    function automatic logic [7:0] ack_pattern(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = SYNC_FIRST;
            2'd1:    b = SYNC_SECOND;
            default: b = ACK_CLASS;
        endcase
        return b;
    endfunction

endpackage

[src/gcfam_frame_ctl.sv]
// Frame and acknowledge state, updated on each accepted item; describes the result run.
module gcfam_frame_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  gcfam_pkg::t_cmd_item i_item,
    output gcfam_pkg::t_run     o_run
);
    import gcfam_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_saved_class, n_saved_class;
    logic [7:0]  r_saved_ident, n_saved_ident;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [1:0]  r_pattern_index, n_pattern_index;
    logic [7:0]  r_held_code, n_held_code;
    logic        r_class_ok, n_class_ok;

    logic [7:0]  len_lo, len_hi;
    logic [7:0]  hdr_a, hdr_b;
    logic [7:0]  pay_a, pay_b;
    logic        ident_ok;
    t_run        run;

    assign len_lo = i_item.payload_length[7:0];
    assign len_hi = i_item.payload_length[15:8];

    // Header sums in closed form: A = c+i+l+h, B = 4c+3i+2l+h
    assign hdr_a = i_item.msg_class + i_item.msg_ident + len_lo + len_hi;
    assign hdr_b = {i_item.msg_class[5:0], 2'b00} + {i_item.msg_ident[6:0], 1'b0}
                 + i_item.msg_ident + {len_lo[6:0], 1'b0} + len_hi;

    assign pay_a = r_sum_a + i_item.data_byte;
    assign pay_b = r_sum_b + pay_a;

    assign ident_ok = r_class_ok && (i_item.data_byte == r_saved_ident);

    always_comb begin
        n_phase         = r_phase;
        n_sum_a         = r_sum_a;
        n_sum_b         = r_sum_b;
        n_saved_class   = r_saved_class;
        n_saved_ident   = r_saved_ident;
        n_bytes_left    = r_bytes_left;
        n_pattern_index = r_pattern_index;
        n_held_code     = r_held_code;
        n_class_ok      = r_class_ok;

        run           = '0;
        run.mode      = RUN_NONE;
        run.hdr_class = i_item.msg_class;
        run.hdr_ident = i_item.msg_ident;
        run.len_lo    = len_lo;
        run.len_hi    = len_hi;
        run.data      = i_item.data_byte;

        if (i_accept) begin
            case (i_item.command)
                CMD_START: begin
                    n_saved_class = i_item.msg_class;
                    n_saved_ident = i_item.msg_ident;
                    n_bytes_left  = i_item.payload_length;
                    n_sum_a       = hdr_a;
                    n_sum_b       = hdr_b;
                    run.sum_a     = hdr_a;
                    run.sum_b     = hdr_b;
                    if (i_item.payload_length == 16'd0) begin
                        run.mode        = RUN_HDR_SUM;
                        n_phase         = PH_SCAN;
                        n_pattern_index = 2'd0;
                    end else begin
                        run.mode = RUN_HDR;
                        n_phase  = PH_PAYLOAD;
                    end
                end
                CMD_PAYLOAD: begin
                    if (r_phase == PH_PAYLOAD) begin
                        n_sum_a      = pay_a;
                        n_sum_b      = pay_b;
                        n_bytes_left = r_bytes_left - 16'd1;
                        run.sum_a    = pay_a;
                        run.sum_b    = pay_b;
                        if (r_bytes_left == 16'd1) begin
                            run.mode        = RUN_BYTE_SUM;
                            n_phase         = PH_SCAN;
                            n_pattern_index = 2'd0;
                        end else begin
                            run.mode = RUN_BYTE;
                        end
                    end
                end
                CMD_RECEIVE: begin
                    case (r_phase)
                        PH_SCAN: begin
                            // advance only on a match, never fall back
                            if (i_item.data_byte == ack_pattern(r_pattern_index)) begin
                                if (r_pattern_index == 2'd2) begin
                                    n_pattern_index = 2'd0;
                                    n_phase         = PH_CODE;
                                end else begin
                                    n_pattern_index = r_pattern_index + 2'd1;
                                end
                            end
                        end
                        PH_CODE: begin
                            n_held_code = i_item.data_byte;
                            n_phase     = PH_LEN_LO;
                        end
                        PH_LEN_LO: n_phase = PH_LEN_HI;
                        PH_LEN_HI: n_phase = PH_CLASS;
                        PH_CLASS: begin
                            n_class_ok = (i_item.data_byte == r_saved_class);
                            n_phase    = PH_IDENT;
                        end
                        PH_IDENT: begin
                            run.mode    = RUN_VERDICT;
                            run.matched = ident_ok;
                            run.code    = ident_ok ? r_held_code : BAD_RESPONSE;
                            n_phase     = PH_IDLE;
                            n_class_ok  = 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_sum_a         <= '0;
            r_sum_b         <= '0;
            r_saved_class   <= '0;
            r_saved_ident   <= '0;
            r_bytes_left    <= '0;
            r_pattern_index <= '0;
            r_held_code     <= '0;
            r_class_ok      <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_sum_a         <= n_sum_a;
            r_sum_b         <= n_sum_b;
            r_saved_class   <= n_saved_class;
            r_saved_ident   <= n_saved_ident;
            r_bytes_left    <= n_bytes_left;
            r_pattern_index <= n_pattern_index;
            r_held_code     <= n_held_code;
            r_class_ok      <= n_class_ok;
        end
    end

`ifndef SYNTHESIS
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_bytes_left != 16'd0))
        else $error("payload phase with no bytes left");

    a_pattern_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern_index != 2'd3)
        else $error("pattern index out of range");
`endif

endmodule

[src/gcfam_emitter.sv]
// Pending run slot, active run register and result sequencing onto the output channel.
module gcfam_emitter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_run_valid,
    input  gcfam_pkg::t_run         i_run,
    output logic                    o_take_ready,
    output logic                    o_valid,
    input  logic                    i_ready,
    output gcfam_pkg::t_result_item o_item
);
    import gcfam_pkg::*;

    logic       r_pend_valid;
    t_run       r_pend;
    logic       r_act_valid;
    t_run       r_act;
    logic [2:0] r_idx;

    logic       at_last;
    logic       act_done;
    logic       act_free;
    logic       pend_move;
    t_result_item item;

    assign at_last   = (r_idx == run_last(r_act.mode));
    assign act_done  = r_act_valid && i_ready && at_last;
    assign act_free  = !r_act_valid || act_done;
    assign pend_move = r_pend_valid && act_free;

    assign o_take_ready = !r_pend_valid || act_free;
    assign o_valid      = r_act_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_act_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_run_valid) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end

            if (pend_move) begin
                r_act_valid <= 1'b1;
                r_idx       <= '0;
            end else if (act_done) begin
                r_act_valid <= 1'b0;
                r_idx       <= '0;
            end else if (r_act_valid && i_ready) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run_valid) begin
            r_pend <= i_run;
        end
        if (pend_move) begin
            r_act <= r_pend;
        end
    end

    always_comb begin
        item             = '0;
        item.last_of_run = at_last;
        case (r_act.mode)
            RUN_HDR, RUN_HDR_SUM: begin
                case (r_idx)
                    3'd0:    item.tx_byte = SYNC_FIRST;
                    3'd1:    item.tx_byte = SYNC_SECOND;
                    3'd2:    item.tx_byte = r_act.hdr_class;
                    3'd3:    item.tx_byte = r_act.hdr_ident;
                    3'd4:    item.tx_byte = r_act.len_lo;
                    3'd5:    item.tx_byte = r_act.len_hi;
                    3'd6:    item.tx_byte = r_act.sum_a;
                    default: item.tx_byte = r_act.sum_b;
                endcase
            end
            RUN_BYTE, RUN_BYTE_SUM: begin
                case (r_idx)
                    3'd0:    item.tx_byte = r_act.data;
                    3'd1:    item.tx_byte = r_act.sum_a;
                    default: item.tx_byte = r_act.sum_b;
                endcase
            end
            RUN_VERDICT: begin
                item.out_kind         = 1'b1;
                item.response_matched = r_act.matched;
                item.response_code    = r_act.code;
            end
            default: ;
        endcase
    end

    assign o_item = item;

`ifndef SYNTHESIS
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_act_valid |-> (r_idx == 3'd0))
        else $error("result index moved with no active run");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_valid |-> (r_idx <= run_last(r_act.mode)))
        else $error("result index beyond end of run");

    a_pend_to_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend_move |=> r_act_valid)
        else $error("pending run lost on transfer");
`endif

endmodule

[src/gps_command_framer_ack_matcher.sv]
// Top level of the command framer with acknowledge matcher.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes commands: start a
// frame, a payload byte to send, or a byte received from the GPS receiver.
// Output channel (o_out_valid / i_out_ready / o_out_item) gives transmit bytes
// and response verdicts, last_of_run marking the final result of each item.
// Frame and checksum state update in the cycle an item is accepted; the
// item's result run sits in a one-deep pending slot, then moves to the active
// run register, which drives the output one result per cycle while
// i_out_ready is high. An item's first result is valid only once its run
// has passed through the pending slot into the active run register.
// Throughput: one item per cycle while each causes at most one result and
// the receiver is ready; a start holds the output for 6 results (8 with
// an empty payload) and the closing payload byte for 3, set by the
// one-result-per-cycle output. Items causing no result queue no run.
// Reset (synchronous, active low) returns to idle and discards queued runs.
// When the receiver stalls, the current result holds and one further item is
// still taken into the pending slot; o_in_ready then drops until it drains.
module gps_command_framer_ack_matcher (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  gcfam_pkg::t_cmd_item    i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output gcfam_pkg::t_result_item o_out_item
);
    import gcfam_pkg::*;

    logic accept;
    t_run run;
    logic run_valid;

    assign accept    = i_in_valid && o_in_ready;
    assign run_valid = accept && (run.mode != RUN_NONE);

    gcfam_frame_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_run    (run)
    );

    gcfam_emitter u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run_valid  (run_valid),
        .i_run        (run),
        .o_take_ready (o_in_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_item       (o_out_item)
    );

endmodule

[tb/sv/gcfam_checker.sv]
// Link checker: predicts framed bytes and reply verdicts, compares them with the output channel.
`timescale 1ns / 1ps

module gcfam_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  gcfam_pkg::t_cmd_item    i_in_item,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  gcfam_pkg::t_result_item i_out_item,
    output int                      o_errors,
    output int                      o_pending
);
    import gcfam_pkg::*;

    // predicted framer / matcher state
    t_phase      phase;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  sent_class;
    logic [7:0]  sent_ident;
    logic [15:0] bytes_left;
    logic [1:0]  sync_pos;
    logic [7:0]  held_code;
    logic        class_ok;

    logic [7:0]   ack_seq [3] = '{SYNC_FIRST, SYNC_SECOND, ACK_CLASS};
    t_result_item due_results [$];
    t_result_item step_out [$];
    t_result_item want;
    int           mismatches = 0;

    assign o_errors = mismatches;

    task automatic report(input string what, input int got, input int exp_val);
        $display("checker: %s got %0h want %0h at %0t", what, got, exp_val, $realtime);
        mismatches++;
    endtask

    function automatic void fold(input logic [7:0] x);
        sum_a = sum_a + x;
        sum_b = sum_b + sum_a;
    endfunction

    function automatic void add_tx(input logic [7:0] b);
        t_result_item r;
        r = '0;
        r.tx_byte = b;
        step_out.push_back(r);
    endfunction

    function automatic void close_frame();
        add_tx(sum_a);
        add_tx(sum_b);
        phase    = PH_SCAN;
        sync_pos = 2'd0;
    endfunction

    function automatic void clear_state();
        phase      = PH_IDLE;
        sum_a      = '0;
        sum_b      = '0;
        sent_class = '0;
        sent_ident = '0;
        bytes_left = '0;
        sync_pos   = '0;
        held_code  = '0;
        class_ok   = 1'b0;
    endfunction

    // Works out the results of one accepted item and queues them as due
    function automatic void frame_and_match(input t_cmd_item it);
        t_result_item v;
        step_out.delete();
        case (it.command)
            CMD_START: begin
                sent_class = it.msg_class;
                sent_ident = it.msg_ident;
                bytes_left = it.payload_length;
                sum_a      = '0;
                sum_b      = '0;
                fold(it.msg_class);
                fold(it.msg_ident);
                fold(it.payload_length[7:0]);
                fold(it.payload_length[15:8]);
                add_tx(SYNC_FIRST);
                add_tx(SYNC_SECOND);
                add_tx(it.msg_class);
                add_tx(it.msg_ident);
                add_tx(it.payload_length[7:0]);
                add_tx(it.payload_length[15:8]);
                if (it.payload_length == 16'd0)
                    close_frame();
                else
                    phase = PH_PAYLOAD;
            end
            CMD_PAYLOAD: begin
                if (phase == PH_PAYLOAD) begin
                    fold(it.data_byte);
                    add_tx(it.data_byte);
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 16'd0)
                        close_frame();
                end
            end
            CMD_RECEIVE: begin
                case (phase)
                    // sync search only ever moves forward
                    PH_SCAN: begin
                        if (it.data_byte == ack_seq[sync_pos]) begin
                            if (sync_pos == 2'd2) begin
                                sync_pos = 2'd0;
                                phase    = PH_CODE;
                            end else begin
                                sync_pos = sync_pos + 2'd1;
                            end
                        end
                    end
                    PH_CODE: begin
                        held_code = it.data_byte;
                        phase     = PH_LEN_LO;
                    end
                    PH_LEN_LO: phase = PH_LEN_HI;
                    PH_LEN_HI: phase = PH_CLASS;
                    PH_CLASS: begin
                        class_ok = (it.data_byte == sent_class);
                        phase    = PH_IDENT;
                    end
                    PH_IDENT: begin
                        v = '0;
                        v.out_kind = 1'b1;
                        if (class_ok && it.data_byte == sent_ident) begin
                            v.response_matched = 1'b1;
                            v.response_code    = held_code;
                        end else begin
                            v.response_code = BAD_RESPONSE;
                        end
                        step_out.push_back(v);
                        phase    = PH_IDLE;
                        class_ok = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i])
            due_results.push_back(step_out[i]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                frame_and_match(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report("result with nothing due, tx_byte",
                           int'(i_out_item.tx_byte), 0);
                end else begin
                    want = due_results.pop_front();
                    if (i_out_item.out_kind !== want.out_kind)
                        report("out_kind", int'(i_out_item.out_kind),
                               int'(want.out_kind));
                    if (i_out_item.tx_byte !== want.tx_byte)
                        report("tx_byte", int'(i_out_item.tx_byte),
                               int'(want.tx_byte));
                    if (i_out_item.last_of_run !== want.last_of_run)
                        report("last_of_run", int'(i_out_item.last_of_run),
                               int'(want.last_of_run));
                    if (i_out_item.response_matched !== want.response_matched)
                        report("response_matched", int'(i_out_item.response_matched),
                               int'(want.response_matched));
                    if (i_out_item.response_code !== want.response_code)
                        report("response_code", int'(i_out_item.response_code),
                               int'(want.response_code));
                end
            end
            o_pending <= due_results.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// Testbench top: clock, reset, command stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
    import gcfam_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [7:0] ACK_CODE   = 8'h01;
    localparam logic [7:0] NAK_CODE   = 8'h00;
    localparam int         ITEM_GOAL  = 150;
    localparam int         HOLD_LEN   = 80;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_ready;
    t_cmd_item    in_item   = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    t_result_item out_item;
    int           errors;
    int           pending;

    bit no_gaps  = 1'b0;
    bit hold_req = 1'b0;
    int sent_items = 0;
    int hold_left  = 0;
    int span       = 0;
    bit span_ready = 1'b0;

    gps_command_framer_ack_matcher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    gcfam_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Receiver side: alternating ready and stall spans, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (span == 0) begin
                span_ready = !span_ready;
                if (span_ready)
                    span = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6)
                                                         : $urandom_range(20, 50);
                else
                    span = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 30);
            end
            span--;
            out_ready <= span_ready;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    function automatic t_cmd_item make_item(input logic [1:0] cmd, input logic [7:0] cls,
                                            input logic [7:0] idn, input logic [15:0] len,
                                            input logic [7:0] d);
        t_cmd_item it;
        it.command        = cmd;
        it.msg_class      = cls;
        it.msg_ident      = idn;
        it.payload_length = len;
        it.data_byte      = d;
        return it;
    endfunction

    function automatic t_cmd_item start_item(input logic [7:0] cls, input logic [7:0] idn,
                                             input logic [15:0] len);
        return make_item(CMD_START, cls, idn, len, 8'($urandom_range(0, 255)));
    endfunction

    function automatic t_cmd_item payload_item(input logic [7:0] d);
        return make_item(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), d);
    endfunction

    function automatic t_cmd_item rx_item(input logic [7:0] d);
        return make_item(CMD_RECEIVE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), d);
    endfunction

    // valid stays up between back-to-back items; lowered only ahead of a gap
    task automatic offer(input t_cmd_item it, input bit counts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (counts)
            sent_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] idn,
                              input logic [15:0] len, input int nbytes);
        offer(start_item(cls, idn, len), 1'b1);
        repeat (nbytes) offer(payload_item(8'($urandom_range(0, 255))), 1'b1);
    endtask

    // Receiver reply: sync, ack class, code, two length bytes, echoed class and id
    task automatic send_reply(input logic [7:0] cls, input logic [7:0] idn,
                              input logic [7:0] code, input int nbytes);
        logic [7:0] seq [8];
        seq = '{SYNC_FIRST, SYNC_SECOND, ACK_CLASS, code, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), cls, idn};
        for (int i = 0; i < nbytes; i++)
            offer(rx_item(seq[i]), 1'b1);
    endtask

    initial begin
        int         round;
        int         pick;
        int         len;
        logic [7:0] cls;
        logic [7:0] idn;
        logic [7:0] code;

        round = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        offer(rx_item(SYNC_FIRST), 1'b0);                                // idle: ignored
        offer(payload_item(8'hFF), 1'b0);                                // idle: ignored
        offer(make_item(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF), 1'b0);
        offer(start_item(8'hFF, 8'hFF, 16'h0000), 1'b0);                 // empty payload
        offer(payload_item(8'h00), 1'b0);                                // scanning: ignored
        offer(rx_item(SYNC_FIRST), 1'b0);
        offer(rx_item(8'h33), 1'b0);                                     // no fall-back
        offer(rx_item(SYNC_SECOND), 1'b0);
        offer(rx_item(ACK_CLASS), 1'b0);
        offer(rx_item(ACK_CODE), 1'b0);
        offer(rx_item(8'h00), 1'b0);
        offer(rx_item(8'h00), 1'b0);
        offer(rx_item(8'hFF), 1'b0);
        offer(rx_item(8'hFF), 1'b0);                                     // matched verdict
        offer(start_item(8'h00, 8'h00, 16'hFFFF), 1'b0);
        offer(payload_item(8'hFF), 1'b0);
        offer(start_item(8'h06, 8'h01, 16'h0001), 1'b0);                 // restart while busy
        offer(payload_item(8'h80), 1'b0);                                // closing byte
        send_reply(8'h07, 8'h01, NAK_CODE, 8);                           // class mismatch
        drain();

        // random part
        while (sent_items < ITEM_GOAL) begin
            round++;
            no_gaps = ($urandom_range(0, 5) == 0);
            cls  = 8'($urandom_range(0, 255));
            idn  = 8'($urandom_range(0, 255));
            code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(NAK_CODE, ACK_CODE));
            if (round % 25 == 0)
                drain();
            pick = $urandom_range(0, 99);
            if (round == 12) begin
                // long receiver hold-off while a frame is still being offered
                hold_req = 1'b1;
                send_frame(cls, idn, 16'd12, 12);
                send_reply(cls, idn, code, 8);
            end else if (pick < 65) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24)
                                                  : $urandom_range(0, 4);
                send_frame(cls, idn, 16'(len), len);
                repeat ($urandom_range(0, 2))
                    offer(rx_item(8'($urandom_range(0, 255))), 1'b1);
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_reply(cls, idn, code, 8);
                else if (pick < 88)
                    send_reply(cls ^ 8'(1 << $urandom_range(0, 7)), idn, code, 8);
                else
                    send_reply(cls, idn ^ 8'(1 << $urandom_range(0, 7)), code, 8);
            end else if (pick < 77) begin
                // frame left unfinished; the next start drops it
                send_frame(cls, idn, 16'($urandom_range(0, 65535)), $urandom_range(0, 3));
            end else if (pick < 89) begin
                len = $urandom_range(0, 3);
                send_frame(cls, idn, 16'(len), len);
                send_reply(cls, idn, code, $urandom_range(1, 7));
            end else begin
                repeat ($urandom_range(1, 4))
                    offer(make_item(2'($urandom_range(CMD_START, CMD_UNUSED)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    16'($urandom_range(0, 65535)),
                                    8'($urandom_range(0, 255))), 1'b1);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
